// ===== hw/rtl/cnmt_pkg.sv =====
// Shared types and constants for the CIDR network match table.
// No dependencies; every other RTL file of the block refers to this package.
package cnmt_pkg;

    localparam int ADDR_W = 128;
    localparam int V4_W   = 32;

    localparam logic       ACT_INSERT  = 1'b0;
    localparam logic       ACT_LOOKUP  = 1'b1;
    localparam logic [7:0] FAM_V4_BITS = 8'd32;
    localparam logic [7:0] FAM_V6_BITS = 8'd128;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_PREFIX = 2'd1,
        ST_FULL       = 2'd2
    } t_status;

    typedef struct packed {
        logic        action;
        logic        is_v6;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic        has_prefix;
        logic [7:0]  prefix_len;
    } t_in;

    typedef struct packed {
        logic       hit;
        logic [1:0] status;
    } t_out;

    // Item as it travels down the row of cells. For an insert, key is the
    // address already masked to its network; for a lookup, the bare address.
    typedef struct packed {
        logic              action;
        logic              is_v6;
        logic [ADDR_W-1:0] key;
        logic [ADDR_W-1:0] mask;
        logic              err;
        logic              placed;
        logic              hit;
    } t_tok;

endpackage

// ===== hw/rtl/cnmt_prep.sv =====
// Entry stage: turns an input item into a chain token with network mask.
// Depends on cnmt_pkg.
module cnmt_prep (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  cnmt_pkg::t_in  i_item,
    output logic           o_vld,
    output cnmt_pkg::t_tok o_tok
);

    localparam logic [cnmt_pkg::ADDR_W-1:0] ALL1 = '1;
    localparam logic [cnmt_pkg::ADDR_W-1:0] V4_ALL1 =
        {{(cnmt_pkg::ADDR_W - cnmt_pkg::V4_W){1'b0}}, {cnmt_pkg::V4_W{1'b1}}};

    logic [cnmt_pkg::ADDR_W-1:0] w_addr;
    logic [cnmt_pkg::ADDR_W-1:0] w_fam;
    logic [cnmt_pkg::ADDR_W-1:0] w_pmask;
    logic [cnmt_pkg::ADDR_W-1:0] w_tzmask;
    logic [cnmt_pkg::ADDR_W-1:0] w_mask;
    logic [cnmt_pkg::V4_W-1:0]   w_pmask4;
    logic [7:0]                  w_fam_bits;
    logic                        w_err;
    cnmt_pkg::t_tok              n_tok;
    cnmt_pkg::t_tok              r_tok;
    logic                        r_vld;

    always_comb begin
        if (i_item.is_v6) begin
            w_addr     = {i_item.addr_high, i_item.addr_low};
            w_fam      = ALL1;
            w_fam_bits = cnmt_pkg::FAM_V6_BITS;
        end else begin
            w_addr     = {{(cnmt_pkg::ADDR_W - cnmt_pkg::V4_W){1'b0}},
                          i_item.addr_low[cnmt_pkg::V4_W-1:0]};
            w_fam      = V4_ALL1;
            w_fam_bits = cnmt_pkg::FAM_V4_BITS;
        end

        // A prefix of n bits keeps the top n bits of the family width.
        w_pmask4 = ~({cnmt_pkg::V4_W{1'b1}} >> i_item.prefix_len);
        if (i_item.is_v6) begin
            w_pmask = ~(ALL1 >> i_item.prefix_len);
        end else begin
            w_pmask = {{(cnmt_pkg::ADDR_W - cnmt_pkg::V4_W){1'b0}}, w_pmask4};
        end

        // Without a prefix, keep every bit from the lowest set bit upward.
        // A zero address compares in full.
        if (w_addr == '0) begin
            w_tzmask = w_fam;
        end else begin
            w_tzmask = (w_addr | (~w_addr + 1'b1)) & w_fam;
        end

        w_mask = i_item.has_prefix ? w_pmask : w_tzmask;
        w_err  = (i_item.action == cnmt_pkg::ACT_INSERT) && i_item.has_prefix &&
                 (i_item.prefix_len > w_fam_bits);

        n_tok.action = i_item.action;
        n_tok.is_v6  = i_item.is_v6;
        n_tok.key    = (i_item.action == cnmt_pkg::ACT_LOOKUP) ? w_addr : (w_addr & w_mask);
        n_tok.mask   = w_mask;
        n_tok.err    = w_err;
        n_tok.placed = 1'b0;
        n_tok.hit    = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;

endmodule

// ===== hw/rtl/cnmt_cell.sv =====
// One cell of the match row: holds up to one IPv4 and one IPv6 table entry, as HAS_V4 and HAS_V6 enable.
// Depends on cnmt_pkg.
module cnmt_cell #(
    parameter bit HAS_V4 = 1'b1,
    parameter bit HAS_V6 = 1'b1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_vld,
    input  cnmt_pkg::t_tok i_tok,
    output logic           o_vld,
    output cnmt_pkg::t_tok o_tok
);

    logic                        r_v4_vld;
    logic [cnmt_pkg::V4_W-1:0]   r_v4_net;
    logic [cnmt_pkg::V4_W-1:0]   r_v4_mask;
    logic                        r_v6_vld;
    logic [cnmt_pkg::ADDR_W-1:0] r_v6_net;
    logic [cnmt_pkg::ADDR_W-1:0] r_v6_mask;
    logic                        r_vld;
    cnmt_pkg::t_tok              r_tok;
    cnmt_pkg::t_tok              n_tok;
    logic                        w_claim4;
    logic                        w_claim6;
    logic                        w_hit4;
    logic                        w_hit6;
    logic                        w_ins;

    always_comb begin
        w_ins    = i_vld && (i_tok.action == cnmt_pkg::ACT_INSERT) &&
                   !i_tok.err && !i_tok.placed;
        w_claim4 = HAS_V4 && w_ins && !i_tok.is_v6 && !r_v4_vld;
        w_claim6 = HAS_V6 && w_ins && i_tok.is_v6 && !r_v6_vld;
        w_hit4   = HAS_V4 && r_v4_vld && !i_tok.is_v6 &&
                   ((i_tok.key[cnmt_pkg::V4_W-1:0] & r_v4_mask) == r_v4_net);
        w_hit6   = HAS_V6 && r_v6_vld && i_tok.is_v6 &&
                   ((i_tok.key & r_v6_mask) == r_v6_net);

        n_tok        = i_tok;
        n_tok.placed = i_tok.placed || w_claim4 || w_claim6;
        n_tok.hit    = i_tok.hit || ((i_tok.action == cnmt_pkg::ACT_LOOKUP) &&
                                     (w_hit4 || w_hit6));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_v4_vld <= 1'b0;
            r_v6_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
            if (w_claim4) begin
                r_v4_vld <= 1'b1;
            end
            if (w_claim6) begin
                r_v6_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok <= n_tok;
            if (w_claim4) begin
                r_v4_net  <= i_tok.key[cnmt_pkg::V4_W-1:0];
                r_v4_mask <= i_tok.mask[cnmt_pkg::V4_W-1:0];
            end
            if (w_claim6) begin
                r_v6_net  <= i_tok.key;
                r_v6_mask <= i_tok.mask;
            end
        end
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;

    // Entries are only ever added; nothing removes them short of reset.
    a_v4_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4_vld |=> r_v4_vld)
        else $error("IPv4 entry lost");

    // An insert that finds this cell empty must take it and leave placed.
    a_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && (w_claim4 || w_claim6)) |=> (o_vld && o_tok.placed))
        else $error("insert passed an empty cell");

    // A lookup never marks itself as stored.
    a_lookup_unplaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vld && (o_tok.action == cnmt_pkg::ACT_LOOKUP)) |-> !o_tok.placed)
        else $error("lookup item marked as placed");

endmodule

// ===== hw/rtl/cidr_network_match_table_top.sv =====
// Top level of the CIDR network match table: entry stage and a row of cells.
// Depends on cnmt_pkg, cnmt_prep and cnmt_cell.
//
//  channel  direction  valid        stall        payload
//  input    in         i_in_valid   o_in_stall   i_in_item  (cnmt_pkg::t_in)
//  output   out        o_out_valid  i_out_stall  o_out_item (cnmt_pkg::t_out)
//
// One item enters per cycle while the output is not stalled; each item passes the
// entry stage register and then one register per cell of the row.
// Each cell holds up to one entry of each family, as V4_ENTRIES and V6_ENTRIES allow, and compares every passing item.
// Reset empties both tables at once; no clearing pass is needed.
// A stall on the output while an item waits there freezes the whole row and stalls the input.
module cidr_network_match_table_top #(
    parameter int V4_ENTRIES = 16,
    parameter int V6_ENTRIES = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  cnmt_pkg::t_in  i_in_item,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output cnmt_pkg::t_out o_out_item
);

    localparam int N_CELLS = (V4_ENTRIES > V6_ENTRIES) ? V4_ENTRIES : V6_ENTRIES;

    logic           w_adv;
    logic           w_vld [0:N_CELLS];
    cnmt_pkg::t_tok w_tok [0:N_CELLS];
    cnmt_pkg::t_tok w_last;

    assign w_adv      = !(w_vld[N_CELLS] && i_out_stall);
    assign o_in_stall = !w_adv;

    cnmt_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_vld   (w_vld[0]),
        .o_tok   (w_tok[0])
    );

    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        cnmt_cell #(
            .HAS_V4 (k < V4_ENTRIES),
            .HAS_V6 (k < V6_ENTRIES)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_vld   (w_vld[k]),
            .i_tok   (w_tok[k]),
            .o_vld   (w_vld[k+1]),
            .o_tok   (w_tok[k+1])
        );
    end

    assign w_last      = w_tok[N_CELLS];
    assign o_out_valid = w_vld[N_CELLS];

    always_comb begin
        o_out_item.hit = w_last.hit;
        if (w_last.err) begin
            o_out_item.status = cnmt_pkg::ST_BAD_PREFIX;
        end else if ((w_last.action == cnmt_pkg::ACT_INSERT) && !w_last.placed) begin
            o_out_item.status = cnmt_pkg::ST_FULL;
        end else begin
            o_out_item.status = cnmt_pkg::ST_OK;
        end
    end

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status != 2'd3))
        else $error("undefined status code");

    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.hit) |-> (o_out_item.status == cnmt_pkg::ST_OK))
        else $error("hit reported with an error status");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without an output stall");

endmodule
